FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, compiled out under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication on clk, disabled in reset
`define VCAA_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// next-cycle implication on clk, disabled in reset
`define VCAA_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define VCAA_ASSERT_IMP(lbl, pre, post, msg)
`define VCAA_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

FILE: hdl/vcaa_pkg.sv
// ----------------------------------------------------------------------------
// vcaa_pkg
// shared widths and types of the contact area accumulator
// ----------------------------------------------------------------------------
package vcaa_pkg;

    localparam int NBR_COUNT = 6;
    localparam int SEL_W     = $clog2(NBR_COUNT);
    localparam int LABEL_W   = 12;
    localparam int AREA_W    = 32;
    // six full faces of one label need three extra bits
    localparam int SUM_W     = AREA_W + 3;
    localparam int ACC_W     = 48;
    localparam int CNT_W     = 3;

    typedef logic [NBR_COUNT-1:0][LABEL_W-1:0] lab_arr_t;

    // neighbour merge status
    typedef struct packed {
        logic [NBR_COUNT-1:0] first;
        logic [CNT_W-1:0]     distinct;
    } nbr_info_t;

endpackage

FILE: hdl/vcaa_ram.sv
// ----------------------------------------------------------------------------
// vcaa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module vcaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/vcaa_merge.sv
// ----------------------------------------------------------------------------
// vcaa_merge
// finds distinct neighbour labels and the face area summed for the selected label
// ----------------------------------------------------------------------------
module vcaa_merge
    import vcaa_pkg::*;
(
    input  lab_arr_t             lab,
    input  logic [NBR_COUNT-1:0] mask,
    input  logic [SEL_W-1:0]     sel,
    input  logic [AREA_W-1:0]    area_x,
    input  logic [AREA_W-1:0]    area_y,
    input  logic [AREA_W-1:0]    area_z,
    output nbr_info_t            info,
    output logic [SUM_W-1:0]     sel_sum
);

    logic [NBR_COUNT-1:0]                 used;
    logic [NBR_COUNT-1:0][NBR_COUNT-1:0] match;
    logic [NBR_COUNT-1:0]                 row;
    logic [AREA_W:0]                      part_x;
    logic [AREA_W:0]                      part_y;
    logic [AREA_W:0]                      part_z;

    // per-axis share: none, one face or two faces
    function automatic logic [AREA_W:0] axis_part(input logic [1:0] hit,
                                                  input logic [AREA_W-1:0] area);
        logic [AREA_W:0] r;
        unique case (hit)
            2'b00:         r = '0;
            2'b01, 2'b10:  r = {1'b0, area};
            default:       r = {area, 1'b0};
        endcase
        return r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < NBR_COUNT; i++)
        begin
            used[i] = mask[i] && (lab[i] != '0);
        end
        for (int k = 0; k < NBR_COUNT; k++)
        begin
            for (int j = 0; j < NBR_COUNT; j++)
            begin
                match[k][j] = used[j] && (lab[j] == lab[k]);
            end
        end
        // a label counts at its first occurrence only
        for (int k = 0; k < NBR_COUNT; k++)
        begin
            info.first[k] = used[k];
            for (int j = 0; j < k; j++)
            begin
                if (match[k][j])
                begin
                    info.first[k] = 1'b0;
                end
            end
        end
        info.distinct = CNT_W'($countones(info.first));

        row = (32'(sel) < 32'(NBR_COUNT)) ? match[sel] : '0;
        part_x  = axis_part(row[1:0], area_x);
        part_y  = axis_part(row[3:2], area_y);
        part_z  = axis_part(row[5:4], area_z);
        sel_sum = SUM_W'(part_x) + SUM_W'(part_y) + SUM_W'(part_z);
    end

endmodule

FILE: hdl/voxel_contact_area_accumulator.sv
// ----------------------------------------------------------------------------
// voxel_contact_area_accumulator
// per-label contact area totals of background voxels, kept in one table
// ----------------------------------------------------------------------------
//
//  channel  signals                              direction  transfer when
//  cfg      cfg_valid cfg_ready cfg_index data   in         cfg_valid & cfg_ready
//  in       in_valid in_ready + voxel fields     in         in_valid & in_ready
//  out      out_valid out_ready + result fields  out        out_valid & out_ready
//
//  a classify item updates k (0..6) distinct in-range labels: one table read per
//  label, pipelined against the write-back
//  a read item does one table read of the label row
//  after reset the table is swept to zero, in_ready low
//  a result waits in the output register while the next item is accepted
//  configuration writes are taken in every cycle, the sweep included
//
`include "assert_macros.svh"

module voxel_contact_area_accumulator
    import vcaa_pkg::*;
#(
    parameter int LABEL_COUNT = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [AREA_W-1:0]  cfg_data,
    // voxel items
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [LABEL_W-1:0] center_label,
    input  logic [LABEL_W-1:0] nbr_px_label,
    input  logic [LABEL_W-1:0] nbr_nx_label,
    input  logic [LABEL_W-1:0] nbr_py_label,
    input  logic [LABEL_W-1:0] nbr_ny_label,
    input  logic [LABEL_W-1:0] nbr_pz_label,
    input  logic [LABEL_W-1:0] nbr_nz_label,
    input  logic [NBR_COUNT-1:0] nbr_inside_mask,
    input  logic               is_vessel,
    input  logic               is_bile,
    // results
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         contact_code,
    output logic [CNT_W-1:0]   distinct_cells,
    output logic [ACC_W-1:0]   total_cell_contact,
    output logic [ACC_W-1:0]   total_vessel_contact,
    output logic [ACC_W-1:0]   total_bile_contact,
    output logic [ACC_W-1:0]   total_nil_contact
);

    localparam int ADDR_W = (LABEL_COUNT > 1) ? $clog2(LABEL_COUNT) : 1;
    localparam int ROW_W  = 4 * ACC_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LABEL_COUNT - 1);

    localparam logic FUNC_CLASSIFY = 1'b0;
    localparam logic FUNC_READ     = 1'b1;

    localparam logic [1:0] CFG_FACE_X = 2'd0;
    localparam logic [1:0] CFG_FACE_Y = 2'd1;
    localparam logic [1:0] CFG_FACE_Z = 2'd2;

    // slot of each category inside a table row
    typedef enum logic [1:0] {CAT_CELL, CAT_VESSEL, CAT_BILE, CAT_NIL} cat_t;
    typedef enum logic [1:0] {CODE_NONE, CODE_CELL, CODE_VESSEL, CODE_BILE} code_t;
    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RUN, S_DONE} state_t;

    // face areas
    logic [AREA_W-1:0] area_x_reg;
    logic [AREA_W-1:0] area_y_reg;
    logic [AREA_W-1:0] area_z_reg;

    // control and output registers
    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [NBR_COUNT-1:0] done_mask_reg, done_mask_next;
    logic                 wb_valid_reg, wb_valid_next;
    logic                 rd_hit_reg, rd_hit_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           code_reg, code_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ACC_W-1:0]     cell_reg, cell_next;
    logic [ACC_W-1:0]     vessel_reg, vessel_next;
    logic [ACC_W-1:0]     bile_reg, bile_next;
    logic [ACC_W-1:0]     nil_reg, nil_next;

    // item and write-back payload
    logic                 func_reg, func_next;
    logic [LABEL_W-1:0]   center_reg, center_next;
    lab_arr_t             lab_reg, lab_next;
    logic [NBR_COUNT-1:0] mask_reg, mask_next;
    logic                 vessel_flag_reg, vessel_flag_next;
    logic                 bile_flag_reg, bile_flag_next;
    logic [ADDR_W-1:0]    wb_addr_reg, wb_addr_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;

    // table port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ROW_W-1:0]  ram_rdata;

    nbr_info_t            info;
    logic [SUM_W-1:0]     sel_sum;
    logic [SEL_W-1:0]     sel;
    logic [NBR_COUNT-1:0] sel_onehot;
    logic [NBR_COUNT-1:0] in_range;
    logic [NBR_COUNT-1:0] pending;
    logic                 classify_active;
    logic                 center_in_range;
    logic [ADDR_W-1:0]    center_addr;
    logic [ADDR_W-1:0]    sel_addr;
    cat_t                 cat;
    code_t                code;
    logic [ACC_W-1:0]     old_acc;
    logic [ACC_W:0]       acc_sum;
    logic [ACC_W-1:0]     new_acc;
    logic [ROW_W-1:0]     wb_row;
    logic                 out_load;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    assign out_valid            = out_valid_reg;
    assign contact_code         = code_reg;
    assign distinct_cells       = cnt_reg;
    assign total_cell_contact   = cell_reg;
    assign total_vessel_contact = vessel_reg;
    assign total_bile_contact   = bile_reg;
    assign total_nil_contact    = nil_reg;

    // configuration writes, an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_x_reg <= AREA_W'(65536);
            area_y_reg <= AREA_W'(65536);
            area_z_reg <= AREA_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_FACE_X)
            begin
                area_x_reg <= cfg_data;
            end
            if (cfg_index == CFG_FACE_Y)
            begin
                area_y_reg <= cfg_data;
            end
            if (cfg_index == CFG_FACE_Z)
            begin
                area_z_reg <= cfg_data;
            end
        end
    end

    vcaa_merge u_merge (
        .lab     (lab_reg),
        .mask    (mask_reg),
        .sel     (sel),
        .area_x  (area_x_reg),
        .area_y  (area_y_reg),
        .area_z  (area_z_reg),
        .info    (info),
        .sel_sum (sel_sum)
    );

    vcaa_ram #(
        .WIDTH (ROW_W),
        .DEPTH (LABEL_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // label decode, pick of the next label to update, category, code and write-back row
    always_comb
    begin
        classify_active = (func_reg == FUNC_CLASSIFY) && (center_reg == '0);
        for (int i = 0; i < NBR_COUNT; i++)
        begin
            in_range[i] = 32'(lab_reg[i]) < 32'(LABEL_COUNT);
        end
        pending = info.first & in_range & ~done_mask_reg & {NBR_COUNT{classify_active}};

        // lowest pending neighbour first
        sel = '0;
        for (int i = NBR_COUNT - 1; i >= 0; i--)
        begin
            if (pending[i])
            begin
                sel = SEL_W'(i);
            end
        end
        sel_onehot = NBR_COUNT'(1) << sel;
        sel_addr   = ADDR_W'(32'(lab_reg[sel]));

        center_in_range = 32'(center_reg) < 32'(LABEL_COUNT);
        center_addr     = ADDR_W'(32'(center_reg));

        priority if (bile_flag_reg)
        begin
            cat = CAT_BILE;
        end
        else if (vessel_flag_reg)
        begin
            cat = CAT_VESSEL;
        end
        else if (info.distinct > CNT_W'(1))
        begin
            cat = CAT_CELL;
        end
        else
        begin
            cat = CAT_NIL;
        end

        priority if (!classify_active)
        begin
            code = CODE_NONE;
        end
        else if (bile_flag_reg && (info.distinct != '0))
        begin
            code = CODE_BILE;
        end
        else if (vessel_flag_reg && (info.distinct != '0))
        begin
            code = CODE_VESSEL;
        end
        else if (info.distinct > CNT_W'(1))
        begin
            code = CODE_CELL;
        end
        else
        begin
            code = CODE_NONE;
        end

        // saturating add into the category slot of the row just read
        old_acc = ram_rdata[int'(cat) * ACC_W +: ACC_W];
        acc_sum = {1'b0, old_acc} + (ACC_W + 1)'(sum_reg);
        new_acc = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
        wb_row  = ram_rdata;
        wb_row[int'(cat) * ACC_W +: ACC_W] = new_acc;
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        done_mask_next   = done_mask_reg;
        wb_valid_next    = 1'b0;
        rd_hit_next      = rd_hit_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        code_next        = code_reg;
        cnt_next         = cnt_reg;
        cell_next        = cell_reg;
        vessel_next      = vessel_reg;
        bile_next        = bile_reg;
        nil_next         = nil_reg;
        func_next        = func_reg;
        center_next      = center_reg;
        lab_next         = lab_reg;
        mask_next        = mask_reg;
        vessel_flag_next = vessel_flag_reg;
        bile_flag_next   = bile_flag_reg;
        wb_addr_next     = wb_addr_reg;
        sum_next         = sum_reg;
        ram_we           = 1'b0;
        ram_waddr        = wb_addr_reg;
        ram_wdata        = wb_row;
        ram_re           = 1'b0;
        ram_raddr        = sel_addr;
        out_load         = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = ADDR_W'(clr_cnt_reg + 1'b1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next        = func;
                    center_next      = center_label;
                    lab_next         = {nbr_nz_label, nbr_pz_label, nbr_ny_label,
                                        nbr_py_label, nbr_nx_label, nbr_px_label};
                    mask_next        = nbr_inside_mask;
                    vessel_flag_next = is_vessel;
                    bile_flag_next   = is_bile;
                    done_mask_next   = '0;
                    state_next       = S_RUN;
                end
            end
            S_RUN:
            begin
                // write back the row read in the previous cycle
                if (wb_valid_reg)
                begin
                    ram_we = 1'b1;
                end
                if (func_reg == FUNC_READ)
                begin
                    ram_re      = center_in_range;
                    ram_raddr   = center_addr;
                    rd_hit_next = center_in_range;
                    state_next  = S_DONE;
                end
                else if (pending != '0)
                begin
                    // the labels updated for one voxel are distinct, so this read never hits the write
                    ram_re         = 1'b1;
                    sum_next       = sel_sum;
                    wb_valid_next  = 1'b1;
                    wb_addr_next   = sel_addr;
                    done_mask_next = done_mask_reg | sel_onehot;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    code_next      = code;
                    cnt_next       = classify_active ? info.distinct : '0;
                    if ((func_reg == FUNC_READ) && rd_hit_reg)
                    begin
                        cell_next   = ram_rdata[int'(CAT_CELL) * ACC_W +: ACC_W];
                        vessel_next = ram_rdata[int'(CAT_VESSEL) * ACC_W +: ACC_W];
                        bile_next   = ram_rdata[int'(CAT_BILE) * ACC_W +: ACC_W];
                        nil_next    = ram_rdata[int'(CAT_NIL) * ACC_W +: ACC_W];
                    end
                    else
                    begin
                        cell_next   = '0;
                        vessel_next = '0;
                        bile_next   = '0;
                        nil_next    = '0;
                    end
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            done_mask_reg <= '0;
            wb_valid_reg  <= 1'b0;
            rd_hit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            code_reg      <= '0;
            cnt_reg       <= '0;
            cell_reg      <= '0;
            vessel_reg    <= '0;
            bile_reg      <= '0;
            nil_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            done_mask_reg <= done_mask_next;
            wb_valid_reg  <= wb_valid_next;
            rd_hit_reg    <= rd_hit_next;
            out_valid_reg <= out_valid_next;
            code_reg      <= code_next;
            cnt_reg       <= cnt_next;
            cell_reg      <= cell_next;
            vessel_reg    <= vessel_next;
            bile_reg      <= bile_next;
            nil_reg       <= nil_next;
        end
    end

    // item payload, no reset needed
    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        center_reg      <= center_next;
        lab_reg         <= lab_next;
        mask_reg        <= mask_next;
        vessel_flag_reg <= vessel_flag_next;
        bile_flag_reg   <= bile_flag_next;
        wb_addr_reg     <= wb_addr_next;
        sum_reg         <= sum_next;
    end

    // checks
    `VCAA_ASSERT_IMP(a_out_slot_free, out_load, !out_valid_reg || out_ready, "result overwrote a waiting result")
    `VCAA_ASSERT_IMP(a_rmw_no_alias, ram_we && ram_re && (state_reg == S_RUN), ram_waddr != ram_raddr, "table read and write hit the same label")
    `VCAA_ASSERT_NXT(a_accept_starts_run, in_valid && in_ready, state_reg == S_RUN, "accepted item did not start")
    `VCAA_ASSERT_IMP(a_read_no_write, (state_reg == S_RUN) && (func_reg == FUNC_READ), !ram_we, "read item modified the table")

endmodule
